// File: hdl/assert_macros.svh
// Assertion helpers; the including module supplies clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CHK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Check that a condition never occurs.
`define CHK_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// File: hdl/hre_pkg.sv
`default_nettype none
package hre_pkg;

	localparam int MAX_LEDS       = 1024;
	localparam int COEF_FRAC_BITS = 14;

	localparam int COEF_W    = 16;
	localparam int BRIGHT_W  = 5;
	localparam int LED_CNT_W = 11;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 16;
	localparam int IDX_W     = $clog2(MAX_LEDS);

	// unsigned 8-bit pixel times signed coefficient, and three of them summed
	localparam int PROD_W = COEF_W + 9;
	localparam int SUM_W  = PROD_W + 2;

	localparam logic [7:0] HDR_BITS = 8'hE0;
	localparam logic [7:0] SAT_MAX  = 8'd255;
	localparam logic [7:0] START_BYTE = 8'h00;
	localparam logic [7:0] END_BYTE   = 8'hFF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF_DIAG  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MINUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_PLUS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT  = 3'd4;

	// byte slots of one pixel's run
	localparam int PH_W = 4;
	localparam logic [PH_W-1:0] PH_START = 4'd0;
	localparam logic [PH_W-1:0] PH_HDR   = 4'd4;
	localparam logic [PH_W-1:0] PH_BLUE  = 4'd5;
	localparam logic [PH_W-1:0] PH_GREEN = 4'd6;
	localparam logic [PH_W-1:0] PH_RED   = 4'd7;
	localparam logic [PH_W-1:0] PH_LAST  = 4'd15;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       run_end;
		logic       frame_end;
	} led_byte_t;

	typedef struct packed {
		logic [7:0] hdr;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       frame_start;
		logic       frame_last;
	} entry_t;

	function automatic logic [7:0] sat8(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-COEF_FRAC_BITS-1:0] q;
		q = s[SUM_W-1:COEF_FRAC_BITS];
		if (s < 0)
			return 8'd0;
		else if (q > (SUM_W-COEF_FRAC_BITS)'(SAT_MAX))
			return SAT_MAX;
		else
			return q[7:0];
	endfunction

endpackage
`default_nettype wire

// File: hdl/hre_fifo.sv
`default_nettype none
`include "assert_macros.svh"
module hre_fifo (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire hre_pkg::entry_t            push_data,
	input  wire logic                       pop,
	output      hre_pkg::entry_t            head,
	output      logic                       empty,
	output      logic [hre_pkg::QCNT_W-1:0] count
);

	hre_pkg::entry_t mem_q [hre_pkg::QDEPTH];
	logic [hre_pkg::QAW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [hre_pkg::QCNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	`CHK_NEVER(a_no_overflow, push && !pop && count_q == hre_pkg::QCNT_W'(hre_pkg::QDEPTH),
		"push into full queue")
	`CHK_NEVER(a_no_underflow, pop && count_q == '0, "pop from empty queue")

endmodule
`default_nettype wire

// File: hdl/hre_front.sv
`default_nettype none
module hre_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [hre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hre_pkg::CFG_DAT_W-1:0] cfg_data,
	input  wire logic                          pixel_valid,
	output      logic                          pixel_ready,
	input  wire hre_pkg::pixel_t               pixel,
	input  wire logic [hre_pkg::QCNT_W-1:0]    q_count,
	output      logic                          q_push,
	output      hre_pkg::entry_t               q_data
);

	logic signed [hre_pkg::COEF_W-1:0]    coef_diag_q, coef_minus_q, coef_plus_q;
	logic [hre_pkg::BRIGHT_W-1:0]         bright_q;
	logic [hre_pkg::LED_CNT_W-1:0]        led_count_q;
	logic [hre_pkg::IDX_W-1:0]            pix_idx_q;

	logic signed [hre_pkg::PROD_W-1:0]    pr_s1 [3];
	logic signed [hre_pkg::PROD_W-1:0]    pg_s1 [3];
	logic signed [hre_pkg::PROD_W-1:0]    pb_s1 [3];
	logic                                 valid_s1, start_s1, last_s1;
	logic [7:0]                           hdr_s1;

	logic                                 accept, last;
	logic [hre_pkg::LED_CNT_W-1:0]        cnt_eff, next_pos;
	logic [hre_pkg::QCNT_W:0]             credits_used;
	logic signed [hre_pkg::PROD_W-1:0]    r_in, g_in, b_in;
	logic signed [hre_pkg::SUM_W-1:0]     sum_r, sum_g, sum_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_diag_q  <= hre_pkg::COEF_W'(16384);
			coef_minus_q <= '0;
			coef_plus_q  <= '0;
			bright_q     <= hre_pkg::BRIGHT_W'(15);
			led_count_q  <= hre_pkg::LED_CNT_W'(96);
		end else if (cfg_we) begin
			unique case (cfg_index)
				hre_pkg::REG_COEF_DIAG:  coef_diag_q  <= cfg_data;
				hre_pkg::REG_COEF_MINUS: coef_minus_q <= cfg_data;
				hre_pkg::REG_COEF_PLUS:  coef_plus_q  <= cfg_data;
				hre_pkg::REG_BRIGHTNESS: bright_q     <= cfg_data[hre_pkg::BRIGHT_W-1:0];
				hre_pkg::REG_LED_COUNT:  led_count_q  <= cfg_data[hre_pkg::LED_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// reserve a queue slot for every item in flight
	assign credits_used = (hre_pkg::QCNT_W+1)'(q_count) + (hre_pkg::QCNT_W+1)'(valid_s1);
	assign pixel_ready  = credits_used < (hre_pkg::QCNT_W+1)'(hre_pkg::QDEPTH);
	assign accept       = pixel_valid && pixel_ready;

	always_comb begin
		if (led_count_q == '0)
			cnt_eff = hre_pkg::LED_CNT_W'(1);
		else if (led_count_q > hre_pkg::LED_CNT_W'(hre_pkg::MAX_LEDS))
			cnt_eff = hre_pkg::LED_CNT_W'(hre_pkg::MAX_LEDS);
		else
			cnt_eff = led_count_q;
	end

	assign next_pos = hre_pkg::LED_CNT_W'(pix_idx_q) + hre_pkg::LED_CNT_W'(1);
	assign last     = next_pos >= cnt_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_idx_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept)
				pix_idx_q <= last ? '0 : pix_idx_q + 1'b1;
		end
	end

	assign r_in = hre_pkg::PROD_W'($signed({1'b0, pixel.red}));
	assign g_in = hre_pkg::PROD_W'($signed({1'b0, pixel.green}));
	assign b_in = hre_pkg::PROD_W'($signed({1'b0, pixel.blue}));

	// products per input component, in coefficient order diag, minus, plus
	always_ff @(posedge clk) begin
		if (accept) begin
			pr_s1[0] <= r_in * coef_diag_q;
			pr_s1[1] <= r_in * coef_minus_q;
			pr_s1[2] <= r_in * coef_plus_q;
			pg_s1[0] <= g_in * coef_diag_q;
			pg_s1[1] <= g_in * coef_minus_q;
			pg_s1[2] <= g_in * coef_plus_q;
			pb_s1[0] <= b_in * coef_diag_q;
			pb_s1[1] <= b_in * coef_minus_q;
			pb_s1[2] <= b_in * coef_plus_q;
			hdr_s1   <= hre_pkg::HDR_BITS | {3'b000, bright_q};
			start_s1 <= (pix_idx_q == '0);
			last_s1  <= last;
		end
	end

	assign sum_r = hre_pkg::SUM_W'(pr_s1[0]) + hre_pkg::SUM_W'(pg_s1[1])
		+ hre_pkg::SUM_W'(pb_s1[2]);
	assign sum_g = hre_pkg::SUM_W'(pr_s1[2]) + hre_pkg::SUM_W'(pg_s1[0])
		+ hre_pkg::SUM_W'(pb_s1[1]);
	assign sum_b = hre_pkg::SUM_W'(pr_s1[1]) + hre_pkg::SUM_W'(pg_s1[2])
		+ hre_pkg::SUM_W'(pb_s1[0]);

	assign q_push = valid_s1;
	always_comb begin
		q_data.hdr         = hdr_s1;
		q_data.blue        = hre_pkg::sat8(sum_b);
		q_data.green       = hre_pkg::sat8(sum_g);
		q_data.red         = hre_pkg::sat8(sum_r);
		q_data.frame_start = start_s1;
		q_data.frame_last  = last_s1;
	end

endmodule
`default_nettype wire

// File: hdl/hre_back.sv
`default_nettype none
`include "assert_macros.svh"
module hre_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire hre_pkg::entry_t   q_head,
	input  wire logic              q_empty,
	output      logic              q_pop,
	output      logic              led_valid,
	input  wire logic              led_ready,
	output      hre_pkg::led_byte_t led
);

	hre_pkg::entry_t          entry_q;
	logic                     busy_q;
	logic [hre_pkg::PH_W-1:0] ph_q, ph_end;
	logic                     out_valid_q;
	hre_pkg::led_byte_t       out_q;
	logic                     emit, done;
	logic [7:0]               cur_byte;

	assign ph_end = entry_q.frame_last ? hre_pkg::PH_LAST : hre_pkg::PH_RED;
	assign emit   = busy_q && (!out_valid_q || led_ready);
	assign done   = emit && (ph_q == ph_end);
	assign q_pop  = !q_empty && (!busy_q || done);

	always_comb begin
		case (ph_q)
			hre_pkg::PH_HDR:   cur_byte = entry_q.hdr;
			hre_pkg::PH_BLUE:  cur_byte = entry_q.blue;
			hre_pkg::PH_GREEN: cur_byte = entry_q.green;
			hre_pkg::PH_RED:   cur_byte = entry_q.red;
			default:           cur_byte = (ph_q < hre_pkg::PH_HDR) ? hre_pkg::START_BYTE
			                                                         : hre_pkg::END_BYTE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			entry_q <= q_head;
		if (emit) begin
			out_q.data_byte <= cur_byte;
			out_q.run_end   <= (ph_q == ph_end);
			out_q.frame_end <= (ph_q == hre_pkg::PH_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			ph_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				ph_q   <= q_head.frame_start ? hre_pkg::PH_START : hre_pkg::PH_HDR;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (emit) begin
				ph_q <= ph_q + 1'b1;
			end
			if (emit)
				out_valid_q <= 1'b1;
			else if (led_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign led_valid = out_valid_q;
	assign led       = out_q;

	`CHK(a_frame_end_closes_run, out_valid_q && out_q.frame_end |-> out_q.run_end,
		"frame end byte not marked as end of run")
	`CHK_NEVER(a_phase_in_range, busy_q && ph_q > ph_end, "byte slot past end of run")

endmodule
`default_nettype wire

// File: hdl/hue_rotate_led_frame_encoder.sv
// Each pixel is sent as header, blue, green and red bytes; the first pixel of a
// frame adds four start bytes before them, the last eight end bytes after them.
// Pixel rate is set by the byte-wide output: one byte per cycle, while led_ready
// and the queue allow. Up to 4 decoded pixels wait in the queue between the
// multiply stage and the byte sequencer. Reset: registers to defaults, pixel
// index to frame start, queue and output empty.
`default_nettype none
module hue_rotate_led_frame_encoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [hre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [hre_pkg::CFG_DAT_W-1:0] cfg_data,
	input  wire logic                          pixel_valid,
	output      logic                          pixel_ready,
	input  wire hre_pkg::pixel_t               pixel,
	output      logic                          led_valid,
	input  wire logic                          led_ready,
	output      hre_pkg::led_byte_t            led
);

	logic                       q_push, q_pop, q_empty;
	hre_pkg::entry_t            q_data, q_head;
	logic [hre_pkg::QCNT_W-1:0] q_count;

	hre_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel),
		.q_count     (q_count),
		.q_push      (q_push),
		.q_data      (q_data)
	);

	hre_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.count     (q_count)
	);

	hre_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.led_valid (led_valid),
		.led_ready (led_ready),
		.led       (led)
	);

endmodule
`default_nettype wire
